/* src/pcc_pkg.sv */
`default_nettype none

package pcc_pkg;

   // Default coordinate width and queue depth
   localparam int COORD_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Step index: fixed 10-bit field, saturating at the smaller of the two limits
   localparam int MAX_STEPS = 1024;
   localparam int STEP_BITS = 10;
   localparam int STEP_CAP  = (MAX_STEPS - 1 > 1023) ? 1023 : MAX_STEPS - 1;

   // Configuration port
   localparam int ID_BITS        = 8;
   localparam int DIST_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Magnitudes above 16 bits can never pass the distance test
   localparam int MAG_BITS = 16;
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam int SUM_BITS = SQ_BITS + 2;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_EDGE   = 2'd1,
      KIND_FOLLOW = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AGENT_A  = 2'd0,
      CSR_AGENT_B  = 2'd1,
      CSR_MIN_DIST = 2'd2
   } csr_index_type;

   // One classified step: which results it produces and where they point
   typedef struct packed {
      logic                 prev_vertex;
      logic                 prev_edge;
      logic                 prev_follow;
      logic                 cur_vertex;
      logic                 cur_follow;
      logic                 last;
      logic [STEP_BITS-1:0] prev_idx;
      logic [STEP_BITS-1:0] cur_idx;
   } pcc_job_type;

endpackage

`default_nettype wire

/* src/pcc_front.sv */
`default_nettype none

module pcc_front import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_a_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_z,
   input  wire logic                         req_a_active,
   input  wire logic signed [COORD_BITS-1:0] req_b_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_z,
   input  wire logic                         req_b_active,
   input  wire logic                         req_last,
   input  wire logic [DIST_BITS-1:0]         min_dist_sq,
   input  wire logic                         q_full,
   output logic                              push_valid,
   output pcc_job_type                       push_job,
   output logic [12*COORD_BITS-1:0]          push_pos
);

   localparam int CB = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int TW = 3 * COORD_BITS;
   localparam logic [STEP_BITS-1:0] STEP_CAP_V = STEP_BITS'(STEP_CAP);

   // Pair state
   logic [TW-1:0]        held_a_ff, held_a_in;
   logic [TW-1:0]        held_b_ff, held_b_in;
   logic                 prev_act_a_ff, prev_act_a_in;
   logic                 prev_act_b_ff, prev_act_b_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 have_prev_ff, have_prev_in;

   // Pipeline stages
   logic                           s1_valid_ff, s1_valid_in;
   pcc_job_type                    s1_job_ff;
   logic [12*CB-1:0]               s1_pos_ff;
   logic [2:0][MAG_BITS-1:0]       s1_mag_ff;
   logic                           s1_big_ff;
   logic                           s2_valid_ff, s2_valid_in;
   pcc_job_type                    s2_job_ff;
   logic [12*CB-1:0]               s2_pos_ff;
   logic [2:0][SQ_BITS-1:0]        s2_sq_ff;
   logic                           s2_big_ff;
   logic [SUM_BITS-1:0]            prev_sum_ff;
   logic                           prev_big_ff;

   logic                           advance;
   logic                           accept;
   logic [TW-1:0]                  in_a, in_b, ca, cb;
   logic [STEP_BITS-1:0]           cur_idx;
   logic                           both_prev, both_cur;
   pcc_job_type                    job0;
   logic signed [DW-1:0]           diff [3];
   logic [DW-1:0]                  mag [3];
   logic [DW+MAG_BITS-1:0]         mag_ext [3];
   logic [2:0][MAG_BITS-1:0]       mag_lo;
   logic [2:0]                     mag_big;
   logic [2:0][SQ_BITS-1:0]        sq;
   logic [SUM_BITS-1:0]            sum;
   logic                           close_cur, close_prev;

   // Whole front moves unless the last stage is blocked by a full queue
   assign advance   = !s2_valid_ff || !q_full;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Effective positions and step index of this item
   assign in_a = {req_a_z, req_a_y, req_a_x};
   assign in_b = {req_b_z, req_b_y, req_b_x};
   assign ca   = req_a_active ? in_a : held_a_ff;
   assign cb   = req_b_active ? in_b : held_b_ff;

   always_comb begin
      if (!have_prev_ff) begin
         cur_idx = '0;
      end else if (step_ff >= STEP_CAP_V) begin
         cur_idx = STEP_CAP_V;
      end else begin
         cur_idx = step_ff + STEP_BITS'(1);
      end
   end

   // Classify the held step and the final step
   assign both_prev = have_prev_ff && prev_act_a_ff && prev_act_b_ff;
   assign both_cur  = req_a_active && req_b_active && req_last;

   always_comb begin
      job0             = '0;
      job0.prev_vertex = both_prev && (held_a_ff == held_b_ff);
      job0.prev_edge   = have_prev_ff && (held_a_ff == cb) && (ca == held_b_ff);
      job0.prev_follow = both_prev;
      job0.cur_vertex  = both_cur && (ca == cb);
      job0.cur_follow  = both_cur;
      job0.last        = req_last;
      job0.prev_idx    = step_ff;
      job0.cur_idx     = cur_idx;
   end

   // Per-axis distance magnitude of the current pair
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]    = DW'(signed'(ca[k*CB +: CB])) - DW'(signed'(cb[k*CB +: CB]));
         mag[k]     = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
         mag_ext[k] = {{MAG_BITS{1'b0}}, mag[k]};
         mag_lo[k]  = mag_ext[k][MAG_BITS-1:0];
         mag_big[k] = |mag_ext[k][DW+MAG_BITS-1:MAG_BITS];
      end
   end

   // Advance pair state on each transfer; drop it at the end of a pair
   always_comb begin
      held_a_in     = held_a_ff;
      held_b_in     = held_b_ff;
      prev_act_a_in = prev_act_a_ff;
      prev_act_b_in = prev_act_b_ff;
      step_in       = step_ff;
      have_prev_in  = have_prev_ff;
      if (accept) begin
         if (req_last) begin
            held_a_in     = '0;
            held_b_in     = '0;
            prev_act_a_in = 1'b0;
            prev_act_b_in = 1'b0;
            step_in       = '0;
            have_prev_in  = 1'b0;
         end else begin
            held_a_in     = ca;
            held_b_in     = cb;
            prev_act_a_in = req_a_active;
            prev_act_b_in = req_b_active;
            step_in       = cur_idx;
            have_prev_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_a_ff     <= '0;
         held_b_ff     <= '0;
         prev_act_a_ff <= 1'b0;
         prev_act_b_ff <= 1'b0;
         step_ff       <= '0;
         have_prev_ff  <= 1'b0;
      end else begin
         held_a_ff     <= held_a_in;
         held_b_ff     <= held_b_in;
         prev_act_a_ff <= prev_act_a_in;
         prev_act_b_ff <= prev_act_b_in;
         step_ff       <= step_in;
         have_prev_ff  <= have_prev_in;
      end
   end

   // Stage valids
   assign s1_valid_in = advance ? accept : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Squares of the axis magnitudes
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq[k] = {{MAG_BITS{1'b0}}, s1_mag_ff[k]} * {{MAG_BITS{1'b0}}, s1_mag_ff[k]};
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_job_ff <= job0;
         s1_pos_ff <= {cb, ca, held_b_ff, held_a_ff};
         s1_mag_ff <= mag_lo;
         s1_big_ff <= |mag_big;
         s2_job_ff <= s1_job_ff;
         s2_pos_ff <= s1_pos_ff;
         s2_sq_ff  <= sq;
         s2_big_ff <= s1_big_ff;
      end
   end

   // Threshold test for this step and for the held one
   assign sum = SUM_BITS'(s2_sq_ff[0]) + SUM_BITS'(s2_sq_ff[1]) + SUM_BITS'(s2_sq_ff[2]);
   assign close_cur  = !s2_big_ff && (sum < SUM_BITS'(min_dist_sq));
   assign close_prev = !prev_big_ff && (prev_sum_ff < SUM_BITS'(min_dist_sq));

   always_comb begin
      push_job             = s2_job_ff;
      push_job.prev_follow = s2_job_ff.prev_follow && close_prev;
      push_job.cur_follow  = s2_job_ff.cur_follow && close_cur;
   end

   assign push_valid = s2_valid_ff && !q_full;
   assign push_pos   = s2_pos_ff;

   // Keep the distance of the step just pushed for the next one
   always_ff @(posedge clock) begin
      if (push_valid) begin
         prev_sum_ff <= sum;
         prev_big_ff <= s2_big_ff;
      end
   end

endmodule

`default_nettype wire

/* src/pcc_queue.sv */
`default_nettype none

module pcc_queue import pcc_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/pcc_back.sv */
`default_nettype none

module pcc_back import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire pcc_job_type            job,
   input  wire logic [12*COORD_BITS-1:0] job_pos,
   output logic                        job_pop,
   input  wire logic [ID_BITS-1:0]     agent_a_id,
   input  wire logic [ID_BITS-1:0]     agent_b_id,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_conflict_kind,
   output logic [ID_BITS-1:0]          rsp_agent_a,
   output logic [ID_BITS-1:0]          rsp_agent_b,
   output logic [STEP_BITS-1:0]        rsp_step_index,
   output logic signed [COORD_BITS-1:0] rsp_pos_a_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_a_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_a_z,
   output logic signed [COORD_BITS-1:0] rsp_pos_b_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_b_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_b_z,
   output logic                        rsp_end_of_run
);

   localparam int CB = COORD_BITS;
   localparam int TW = 3 * COORD_BITS;

   // Pending-result bits, in reporting order
   localparam int BIT_PV   = 0;
   localparam int BIT_PE   = 1;
   localparam int BIT_PF   = 2;
   localparam int BIT_CV   = 3;
   localparam int BIT_CF   = 4;
   localparam int BIT_DONE = 5;

   logic [5:0]           mask_ff, mask_in;
   logic [STEP_BITS-1:0] prev_idx_ff, cur_idx_ff;
   logic [12*CB-1:0]     pos_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff;
   logic [ID_BITS-1:0]   agent_a_ff, agent_b_ff;
   logic [STEP_BITS-1:0] idx_ff;
   logic [TW-1:0]        pos_a_ff, pos_b_ff;
   logic                 end_ff;

   logic                 out_free, emit, use_cur;
   logic [5:0]           low, rest, new_mask;
   kind_type             kind_sel;

   // Pick the first pending result of the job in hand
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign low      = mask_ff & (~mask_ff + 6'd1);
   assign emit     = out_free && (mask_ff != '0);
   assign rest     = emit ? (mask_ff & ~low) : mask_ff;
   assign job_pop  = job_valid && (rest == '0);
   assign use_cur  = low[BIT_CV] || low[BIT_CF] || low[BIT_DONE];

   always_comb begin
      new_mask           = '0;
      new_mask[BIT_PV]   = job.prev_vertex;
      new_mask[BIT_PE]   = job.prev_edge;
      new_mask[BIT_PF]   = job.prev_follow;
      new_mask[BIT_CV]   = job.cur_vertex;
      new_mask[BIT_CF]   = job.cur_follow;
      new_mask[BIT_DONE] = job.last;
   end

   assign mask_in = job_pop ? new_mask : rest;

   always_comb begin
      if (low[BIT_PV] || low[BIT_CV]) begin
         kind_sel = KIND_VERTEX;
      end else if (low[BIT_PE]) begin
         kind_sel = KIND_EDGE;
      end else if (low[BIT_PF] || low[BIT_CF]) begin
         kind_sel = KIND_FOLLOW;
      end else begin
         kind_sel = KIND_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // Load the next job
   always_ff @(posedge clock) begin
      if (job_pop) begin
         prev_idx_ff <= job.prev_idx;
         cur_idx_ff  <= job.cur_idx;
         pos_ff      <= job_pos;
      end
   end

   // Output register
   assign rsp_valid_in = out_free ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff    <= kind_sel;
         agent_a_ff <= agent_a_id;
         agent_b_ff <= agent_b_id;
         idx_ff     <= use_cur ? cur_idx_ff : prev_idx_ff;
         pos_a_ff   <= use_cur ? pos_ff[2*TW +: TW] : pos_ff[0 +: TW];
         pos_b_ff   <= use_cur ? pos_ff[3*TW +: TW] : pos_ff[TW +: TW];
         end_ff     <= (rest == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_conflict_kind = kind_ff;
   assign rsp_agent_a       = agent_a_ff;
   assign rsp_agent_b       = agent_b_ff;
   assign rsp_step_index    = idx_ff;
   assign rsp_pos_a_x       = pos_a_ff[0 +: CB];
   assign rsp_pos_a_y       = pos_a_ff[CB +: CB];
   assign rsp_pos_a_z       = pos_a_ff[2*CB +: CB];
   assign rsp_pos_b_x       = pos_b_ff[0 +: CB];
   assign rsp_pos_b_y       = pos_b_ff[CB +: CB];
   assign rsp_pos_b_z       = pos_b_ff[2*CB +: CB];
   assign rsp_end_of_run    = end_ff;

endmodule

`default_nettype wire

/* src/path_pair_conflict_check.sv */
`default_nettype none

// Conflict checker for one pair of agent paths on a 3-D grid. Each request
// carries one time step of both paths; the step is judged when the next one
// arrives (an edge swap needs both steps), so the vertex, edge and following
// results of step t leave after the request for step t+1. The request marked
// last also gets its own vertex and following checks and then a pair-finished
// result, after which the pair state starts from zero. Every request that
// causes results marks its final one with rsp_end_of_run; most cause none.
// A request is taken every cycle unless the queue is full: the front pipeline
// has three stages (classify, square, sum and compare); results then pass the
// queue, the back end's pending mask and its output register. The back end
// sends one result per cycle unless rsp_stall holds it, and drops a request
// without results; a burst of up to six results from one request is absorbed
// by the queue between the two, and the request side stalls only while that
// queue is full. Write the csr_ registers only while no request is in flight.

module path_pair_conflict_check import pcc_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_BITS-1:0]  req_a_x,
   input  wire logic signed [COORD_BITS-1:0]  req_a_y,
   input  wire logic signed [COORD_BITS-1:0]  req_a_z,
   input  wire logic                          req_a_active,
   input  wire logic signed [COORD_BITS-1:0]  req_b_x,
   input  wire logic signed [COORD_BITS-1:0]  req_b_y,
   input  wire logic signed [COORD_BITS-1:0]  req_b_z,
   input  wire logic                          req_b_active,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_conflict_kind,
   output logic [ID_BITS-1:0]                 rsp_agent_a,
   output logic [ID_BITS-1:0]                 rsp_agent_b,
   output logic [STEP_BITS-1:0]               rsp_step_index,
   output logic signed [COORD_BITS-1:0]       rsp_pos_a_x,
   output logic signed [COORD_BITS-1:0]       rsp_pos_a_y,
   output logic signed [COORD_BITS-1:0]       rsp_pos_a_z,
   output logic signed [COORD_BITS-1:0]       rsp_pos_b_x,
   output logic signed [COORD_BITS-1:0]       rsp_pos_b_y,
   output logic signed [COORD_BITS-1:0]       rsp_pos_b_z,
   output logic                               rsp_end_of_run
);

   localparam int PW = 12 * COORD_BITS;
   localparam int JW = $bits(pcc_job_type);
   localparam int QW = JW + PW;

   logic [ID_BITS-1:0]   agent_a_id_ff, agent_a_id_in;
   logic [ID_BITS-1:0]   agent_b_id_ff, agent_b_id_in;
   logic [DIST_BITS-1:0] min_dist_ff, min_dist_in;

   logic                 q_full, push_valid, q_valid, q_pop;
   pcc_job_type          push_job, pop_job;
   logic [PW-1:0]        push_pos, pop_pos;
   logic [QW-1:0]        q_out;

   // Configuration registers; unknown indexes are ignored
   always_comb begin
      agent_a_id_in = agent_a_id_ff;
      agent_b_id_in = agent_b_id_ff;
      min_dist_in   = min_dist_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_AGENT_A:  agent_a_id_in = csr_wdata[ID_BITS-1:0];
            CSR_AGENT_B:  agent_b_id_in = csr_wdata[ID_BITS-1:0];
            CSR_MIN_DIST: min_dist_in   = csr_wdata[DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agent_a_id_ff <= ID_BITS'(0);
         agent_b_id_ff <= ID_BITS'(1);
         min_dist_ff   <= DIST_BITS'(4);
      end else begin
         agent_a_id_ff <= agent_a_id_in;
         agent_b_id_ff <= agent_b_id_in;
         min_dist_ff   <= min_dist_in;
      end
   end

   pcc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_a_x      (req_a_x),
      .req_a_y      (req_a_y),
      .req_a_z      (req_a_z),
      .req_a_active (req_a_active),
      .req_b_x      (req_b_x),
      .req_b_y      (req_b_y),
      .req_b_z      (req_b_z),
      .req_b_active (req_b_active),
      .req_last     (req_last),
      .min_dist_sq  (min_dist_ff),
      .q_full       (q_full),
      .push_valid   (push_valid),
      .push_job     (push_job),
      .push_pos     (push_pos)
   );

   pcc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_job, push_pos}),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out)
   );

   assign pop_job = q_out[QW-1:PW];
   assign pop_pos = q_out[PW-1:0];

   pcc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (q_valid),
      .job               (pop_job),
      .job_pos           (pop_pos),
      .job_pop           (q_pop),
      .agent_a_id        (agent_a_id_ff),
      .agent_b_id        (agent_b_id_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_conflict_kind (rsp_conflict_kind),
      .rsp_agent_a       (rsp_agent_a),
      .rsp_agent_b       (rsp_agent_b),
      .rsp_step_index    (rsp_step_index),
      .rsp_pos_a_x       (rsp_pos_a_x),
      .rsp_pos_a_y       (rsp_pos_a_y),
      .rsp_pos_a_z       (rsp_pos_a_z),
      .rsp_pos_b_x       (rsp_pos_b_x),
      .rsp_pos_b_y       (rsp_pos_b_y),
      .rsp_pos_b_z       (rsp_pos_b_z),
      .rsp_end_of_run    (rsp_end_of_run)
   );

endmodule

`default_nettype wire
